FILE: sv/ssp_pkg.sv
// Shared constants and types for the single-source shortest path block.
`timescale 1ns / 1ps
`default_nettype none

package ssp_pkg;

   localparam int NODES         = 32;
   localparam int EDGE_CAPACITY = 256;
   localparam int WEIGHT_BITS   = 8;

   // Fixed field widths of the ports
   localparam int ACTION_W   = 2;
   localparam int NODE_FW    = 5;
   localparam int WEIGHT_FW  = 8;
   localparam int CFG_W      = 6;
   localparam int DIST_OUT_W = 16;

   localparam int NODE_AW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int NODE_CW = $clog2(NODES + 1);
   localparam int CMP_W   = (NODE_CW > NODE_FW) ? NODE_CW : NODE_FW;
   localparam int EDGE_AW = (EDGE_CAPACITY > 1) ? $clog2(EDGE_CAPACITY) : 1;
   localparam int EDGE_CW = $clog2(EDGE_CAPACITY + 1);
   // wide enough for any simple path's cost, plus a saturation bit above the output width
   localparam int DIST_W  = (NODE_AW + WEIGHT_BITS > DIST_OUT_W + 1) ?
                            (NODE_AW + WEIGHT_BITS) : (DIST_OUT_W + 1);

   localparam logic [CFG_W-1:0]      NODE_COUNT_RESET = 6'd32;
   localparam logic [DIST_OUT_W-1:0] DIST_SAT         = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD   = 2'd0,
      ACT_RUN   = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef struct packed {
      logic [NODE_FW-1:0]     tail;
      logic [NODE_FW-1:0]     head;
      logic [WEIGHT_BITS-1:0] wt;
   } edge_type;

   typedef struct packed {
      logic              valid;
      logic              settled;
      logic [DIST_W-1:0] cost;
   } node_type;

endpackage

`default_nettype wire

FILE: sv/single_source_shortest_path_top.sv
// Top level: edge store, Dijkstra sequencer over a node RAM, result emitter.
// Add and clear beats leave busy low.
// A run beat holds busy through an init pass over the n nodes, then per settled
// node one scan over the node RAM and one edge sweep over the store, then a
// final scan and the output pass. Results come one per cycle in the output
// pass, registered after each node RAM read; no stall.
// Reset empties the edge store, clears the dropped flag, sets node_count to 32.
`timescale 1ns / 1ps
`default_nettype none

module single_source_shortest_path_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [ssp_pkg::CFG_W-1:0]         csr_wr_data,
   input  logic                              start,
   output logic                              busy,
   input  logic [ssp_pkg::ACTION_W-1:0]      req_action,
   input  logic [ssp_pkg::NODE_FW-1:0]       req_from_node,
   input  logic [ssp_pkg::NODE_FW-1:0]       req_to_node,
   input  logic [ssp_pkg::WEIGHT_FW-1:0]     req_weight,
   input  logic [ssp_pkg::NODE_FW-1:0]       req_source_node,
   output logic                              rsp_strobe,
   output logic [ssp_pkg::NODE_FW-1:0]       rsp_node_index,
   output logic [ssp_pkg::DIST_OUT_W-1:0]    rsp_distance,
   output logic                              rsp_reachable,
   output logic                              rsp_edges_dropped,
   output logic                              rsp_last
);
   import ssp_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_INIT  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_RELAX = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [CFG_W-1:0]       node_count_ff;
   logic [NODE_CW-1:0]     n_eff;
   logic [NODE_CW-1:0]     n_ff, n_in;
   logic [NODE_FW-1:0]     src_ff, src_in;
   logic [EDGE_CW-1:0]     edge_cnt_ff, edge_cnt_in;
   logic                   ovf_ff, ovf_in;
   logic [NODE_CW-1:0]     iss_ff, iss_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [NODE_AW-1:0]     rd_idx_ff, rd_idx_in;
   logic                   best_found_ff, best_found_in;
   logic [NODE_AW-1:0]     best_ff, best_in;
   logic [DIST_W-1:0]      best_dist_ff, best_dist_in;
   logic [EDGE_CW-1:0]     e_iss_ff, e_iss_in;
   logic                   s1_vld_ff, s1_vld_in;
   logic                   s2_vld_ff, s2_vld_in;
   logic [NODE_AW-1:0]     s2_head_ff, s2_head_in;
   logic [DIST_W-1:0]      s2_cand_ff, s2_cand_in;
   logic                   lw_vld_ff, lw_vld_in;
   logic [NODE_AW-1:0]     lw_addr_ff, lw_addr_in;
   node_type               lw_data_ff, lw_data_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [NODE_FW-1:0]     rsp_node_index_ff, rsp_node_index_in;
   logic [DIST_OUT_W-1:0]  rsp_distance_ff, rsp_distance_in;
   logic                   rsp_reachable_ff, rsp_reachable_in;
   logic                   rsp_edges_dropped_ff, rsp_edges_dropped_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   accept;
   logic                   e_we;
   logic [EDGE_AW-1:0]     e_waddr, e_raddr;
   edge_type               e_wdata, e_rdata;
   logic                   n_we;
   logic [NODE_AW-1:0]     n_waddr, n_raddr;
   node_type               n_wdata, n_rdata, cur;

   ssp_ram #(.WIDTH($bits(edge_type)), .DEPTH(EDGE_CAPACITY)) u_edge_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_addr (e_raddr),
      .rd_data (e_rdata)
   );

   ssp_ram #(.WIDTH($bits(node_type)), .DEPTH(NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_waddr),
      .wr_data (n_wdata),
      .rd_addr (n_raddr),
      .rd_data (n_rdata)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_node_index    = rsp_node_index_ff;
   assign rsp_distance      = rsp_distance_ff;
   assign rsp_reachable     = rsp_reachable_ff;
   assign rsp_edges_dropped = rsp_edges_dropped_ff;
   assign rsp_last          = rsp_last_ff;

   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = NODE_CW'(1);
      end else if ({1'b0, node_count_ff} > (CFG_W + 1)'(NODES)) begin
         n_eff = NODE_CW'(NODES);
      end else begin
         n_eff = NODE_CW'(node_count_ff);
      end
   end

   // entry seen by the relax compare; covers the write the RAM read missed
   assign cur = (lw_vld_ff && lw_addr_ff == s2_head_ff) ? lw_data_ff : n_rdata;

   always_comb begin
      state_in             = state_ff;
      n_in                 = n_ff;
      src_in               = src_ff;
      edge_cnt_in          = edge_cnt_ff;
      ovf_in               = ovf_ff;
      iss_in               = iss_ff;
      rd_vld_in            = 1'b0;
      rd_idx_in            = rd_idx_ff;
      best_found_in        = best_found_ff;
      best_in              = best_ff;
      best_dist_in         = best_dist_ff;
      e_iss_in             = e_iss_ff;
      s1_vld_in            = 1'b0;
      s2_vld_in            = 1'b0;
      s2_head_in           = s2_head_ff;
      s2_cand_in           = s2_cand_ff;
      rsp_strobe_in        = 1'b0;
      rsp_node_index_in    = rsp_node_index_ff;
      rsp_distance_in      = rsp_distance_ff;
      rsp_reachable_in     = rsp_reachable_ff;
      rsp_edges_dropped_in = rsp_edges_dropped_ff;
      rsp_last_in          = 1'b0;
      e_we                 = 1'b0;
      e_waddr              = edge_cnt_ff[EDGE_AW-1:0];
      e_wdata.tail         = req_from_node;
      e_wdata.head         = req_to_node;
      e_wdata.wt           = WEIGHT_BITS'(req_weight);
      e_raddr              = e_iss_ff[EDGE_AW-1:0];
      n_we                 = 1'b0;
      n_waddr              = iss_ff[NODE_AW-1:0];
      n_wdata              = '0;
      n_raddr              = iss_ff[NODE_AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_ADD: begin
                     if (edge_cnt_ff >= EDGE_CW'(EDGE_CAPACITY)) begin
                        ovf_in = 1'b1;
                     end else begin
                        e_we        = 1'b1;
                        edge_cnt_in = edge_cnt_ff + EDGE_CW'(1);
                     end
                  end
                  ACT_RUN: begin
                     n_in     = n_eff;
                     src_in   = req_source_node;
                     iss_in   = '0;
                     state_in = ST_INIT;
                  end
                  ACT_CLEAR: begin
                     edge_cnt_in = '0;
                     ovf_in      = 1'b0;
                  end
                  default: ;
               endcase
            end
         end

         ST_INIT: begin
            n_we          = 1'b1;
            n_wdata.valid = (CMP_W'(iss_ff) == CMP_W'(src_ff));
            iss_in        = iss_ff + NODE_CW'(1);
            if (iss_ff == n_ff - NODE_CW'(1)) begin
               iss_in        = '0;
               best_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (iss_ff != n_ff) begin
               iss_in    = iss_ff + NODE_CW'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = iss_ff[NODE_AW-1:0];
            end
            // strict less keeps the lowest index on a tie
            if (rd_vld_ff && n_rdata.valid && !n_rdata.settled &&
                (!best_found_ff || n_rdata.cost < best_dist_ff)) begin
               best_found_in = 1'b1;
               best_in       = rd_idx_ff;
               best_dist_in  = n_rdata.cost;
            end
            if (iss_ff == n_ff && !rd_vld_ff) begin
               iss_in = '0;
               if (best_found_ff) begin
                  n_we            = 1'b1;
                  n_waddr         = best_ff;
                  n_wdata.valid   = 1'b1;
                  n_wdata.settled = 1'b1;
                  n_wdata.cost    = best_dist_ff;
                  e_iss_in        = '0;
                  state_in        = ST_RELAX;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end

         ST_RELAX: begin
            if (e_iss_ff != edge_cnt_ff) begin
               e_iss_in  = e_iss_ff + EDGE_CW'(1);
               s1_vld_in = 1'b1;
            end
            // edge beat back from the store: fetch its head entry, used only on a match
            n_raddr = NODE_AW'(e_rdata.head);
            if (s1_vld_ff) begin
               s2_vld_in  = (CMP_W'(e_rdata.tail) == CMP_W'(best_ff)) &&
                            (CMP_W'(e_rdata.head) < CMP_W'(n_ff));
               s2_head_in = NODE_AW'(e_rdata.head);
               s2_cand_in = best_dist_ff + DIST_W'(e_rdata.wt);
            end
            if (s2_vld_ff && (!cur.valid || s2_cand_ff < cur.cost)) begin
               n_we            = 1'b1;
               n_waddr         = s2_head_ff;
               n_wdata.valid   = 1'b1;
               n_wdata.settled = cur.settled;
               n_wdata.cost    = s2_cand_ff;
            end
            if (e_iss_ff == edge_cnt_ff && !s1_vld_ff && !s2_vld_ff) begin
               iss_in        = '0;
               best_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end

         ST_OUT: begin
            if (iss_ff != n_ff) begin
               iss_in    = iss_ff + NODE_CW'(1);
               rd_vld_in = 1'b1;
               rd_idx_in = iss_ff[NODE_AW-1:0];
            end
            if (rd_vld_ff) begin
               rsp_strobe_in        = 1'b1;
               rsp_node_index_in    = NODE_FW'(rd_idx_ff);
               rsp_reachable_in     = n_rdata.valid;
               rsp_edges_dropped_in = ovf_ff;
               rsp_last_in          = (NODE_CW'(rd_idx_ff) == n_ff - NODE_CW'(1));
               if (!n_rdata.valid || n_rdata.cost[DIST_W-1:DIST_OUT_W] != '0) begin
                  rsp_distance_in = DIST_SAT;
               end else begin
                  rsp_distance_in = n_rdata.cost[DIST_OUT_W-1:0];
               end
            end
            if (iss_ff == n_ff && !rd_vld_ff) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      lw_vld_in  = n_we;
      lw_addr_in = n_waddr;
      lw_data_in = n_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= NODE_COUNT_RESET;
         edge_cnt_ff   <= '0;
         ovf_ff        <= 1'b0;
         iss_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         e_iss_ff      <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         lw_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
         edge_cnt_ff   <= edge_cnt_in;
         ovf_ff        <= ovf_in;
         iss_ff        <= iss_in;
         rd_vld_ff     <= rd_vld_in;
         best_found_ff <= best_found_in;
         e_iss_ff      <= e_iss_in;
         s1_vld_ff     <= s1_vld_in;
         s2_vld_ff     <= s2_vld_in;
         lw_vld_ff     <= lw_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff                 <= n_in;
      src_ff               <= src_in;
      rd_idx_ff            <= rd_idx_in;
      best_ff              <= best_in;
      best_dist_ff         <= best_dist_in;
      s2_head_ff           <= s2_head_in;
      s2_cand_ff           <= s2_cand_in;
      lw_addr_ff           <= lw_addr_in;
      lw_data_ff           <= lw_data_in;
      rsp_node_index_ff    <= rsp_node_index_in;
      rsp_distance_ff      <= rsp_distance_in;
      rsp_reachable_ff     <= rsp_reachable_in;
      rsp_edges_dropped_ff <= rsp_edges_dropped_in;
      rsp_last_ff          <= rsp_last_in;
   end

   a_strobe_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == ST_OUT)
      else $error("result beat outside the output phase");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_strobe)
      else $error("last flag without a result beat");

   a_edge_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      edge_cnt_ff <= EDGE_CW'(EDGE_CAPACITY))
      else $error("edge count above capacity");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_RUN) |=> busy)
      else $error("run beat did not raise busy");

   a_node_write_busy: assert property (@(posedge clock) disable iff (reset)
      n_we |-> state_ff != ST_IDLE)
      else $error("node RAM written while idle");

   a_edge_write_idle: assert property (@(posedge clock) disable iff (reset)
      e_we |-> state_ff == ST_IDLE)
      else $error("edge store written during a run");

endmodule

`default_nettype wire

FILE: sv/ssp_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module ssp_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-first: a same-cycle write is not seen
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire
